@@ design/midi_track_event_parser_top_assert.svh @@
// assertion macros for the midi track event parser
// the checks are compiled in simulation only, and the macros are empty for synthesis
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MTEP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mtep assertion failed");
`define MTEP_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("mtep forbidden condition seen");
`else
`define MTEP_ASSERT(lbl, clk, rstn, prop)
`define MTEP_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ design/mtep_pkg.sv @@
// shared types and constants for the midi track event parser
// no dependencies
package mtep_pkg;

  // delta and length quantities end after at most this many bytes
  localparam int unsigned VLQ_MAX_BYTES = 4;

  // decoupling queue between parser and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // byte codes
  localparam logic [7:0] BYTE_META   = 8'hFF;
  localparam logic [7:0] BYTE_SYSEX  = 8'hF0;
  localparam logic [7:0] BYTE_ESCAPE = 8'hF7;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [27:0] TEMPO_LEN  = 28'd3;

  // status upper nibbles
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_POLY_AT   = 4'hA;
  localparam logic [3:0] ST_CTRL      = 4'hB;
  localparam logic [3:0] ST_PROGRAM   = 4'hC;
  localparam logic [3:0] ST_CHAN_AT   = 4'hD;
  localparam logic [3:0] ST_PITCH     = 4'hE;

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_EVENT,
    PH_DATA1,
    PH_DATA2,
    PH_DATA_ONE,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_BODY,
    PH_SYSEX_LEN,
    PH_SYSEX_BODY
  } phase_e;

  typedef enum logic [1:0] {
    KIND_MSG,
    KIND_TEMPO,
    KIND_END
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  tick;
    logic [3:0]   msg_type;
    logic [3:0]   channel;
    logic [7:0]   first_data;
    logic [7:0]   second_data;
    logic [23:0]  tempo_us;
    logic [31:0]  longest_ticks;
    logic         last;
  } result_t;

  // everything one byte causes: one or two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } rec_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic has_two_data(logic [3:0] t);
    case (t)
      ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic has_one_data(logic [3:0] t);
    case (t)
      ST_PROGRAM, ST_CHAN_AT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

@@ design/mtep_if.sv @@
// stream interfaces for the midi track event parser: byte input and result output
// valid/ready handshake, beat moves when both are high; no dependencies
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_track;

  modport source(output valid, output data_byte, output last_of_track, input ready);
  modport sink(input valid, input data_byte, input last_of_track, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] tick;
  logic [3:0]  msg_type;
  logic [3:0]  channel;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [23:0] tempo_us;
  logic [31:0] longest_ticks;
  logic        last;

  modport source(output valid, output kind, output tick, output msg_type, output channel,
                 output first_data, output second_data, output tempo_us,
                 output longest_ticks, output last, input ready);
  modport sink(input valid, input kind, input tick, input msg_type, input channel,
               input first_data, input second_data, input tempo_us,
               input longest_ticks, input last, output ready);
endinterface

@@ design/midi_track_event_parser_top.sv @@
// Track chunk parser for standard MIDI file bodies.
// Input channel in_i takes one byte of a track chunk body per beat, with
// last_of_track set on the final byte. Output channel out_o gives result beats:
// channel messages (running status honored), tempo changes from tempo meta
// events, and one end-of-track beat per track carrying the track's total ticks
// and the largest total seen since reset. Sysex and other meta events are
// dropped. The last field marks the final beat caused by one input byte.
// Throughput: one byte per cycle while the queue is not full. A byte that
// causes two results (the final byte of a track ending on a message or tempo)
// gives two output beats; a four-record queue between the parser and the
// output register absorbs this. A result beat passes from its accepted byte
// through the queue and then the output register before it is valid.
// Reset clears the parser to expect a delta time, zeroes tick and longest
// total, and empties the queue and output register.
// When the receiver stalls, results wait in the output register and the queue;
// in_i.ready drops only once the queue is full.
// Depends on mtep_pkg, mtep_if, mtep_front, mtep_queue and mtep_back.
module midi_track_event_parser_top import mtep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtep_in_if.sink    in_i,
  mtep_out_if.source out_o
);

  logic   push;
  logic   pop;
  rec_t   rec;
  rec_t   head;
  qstat_t q_stat;

  // byte parser
  mtep_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .rec_o    (rec)
  );

  // decoupling queue
  mtep_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // result beats
  mtep_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

@@ design/mtep_front.sv @@
// parser front end: takes one track byte per beat and builds its result record
// depends on mtep_pkg and mtep_in_if
module mtep_front import mtep_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  mtep_in_if.sink        in_i,
  input  qstat_t         q_stat_i,
  output logic           push_o,
  output rec_t           rec_o
);

  phase_e       phase_q, phase_d;
  logic [31:0]  abs_tick_q, abs_tick_d;
  logic [27:0]  vlq_value_q, vlq_value_d;
  logic [2:0]   vlq_count_q, vlq_count_d;
  logic [7:0]   run_status_q, run_status_d;
  logic [7:0]   cur_status_q, cur_status_d;
  logic [7:0]   held_data_q, held_data_d;
  logic [7:0]   meta_kind_q, meta_kind_d;
  logic [27:0]  skip_q, skip_d;
  logic [23:0]  tempo_acc_q, tempo_acc_d;
  logic [1:0]   tempo_cnt_q, tempo_cnt_d;
  logic [31:0]  max_total_q, max_total_d;

  logic         accept;
  logic [7:0]   b;
  logic         fin;
  logic [27:0]  vlq_next;
  logic [2:0]   vlq_cnt_next;
  logic         vlq_done;
  logic [27:0]  skip_dec;
  logic [23:0]  tempo_acc_next;
  logic [1:0]   tempo_cnt_next;
  logic         run_two;
  logic         run_one;
  logic         byte_two;
  logic         byte_one;
  logic [31:0]  tick_add;
  logic [31:0]  tick_sum;
  logic         ev_valid;
  result_t      ev;
  result_t      end_res;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !q_stat_i.full;
  assign b   = in_i.data_byte;
  assign fin = in_i.last_of_track;

  // shared helpers for quantities, skip and tempo
  assign vlq_next       = {vlq_value_q[20:0], b[6:0]};
  assign vlq_cnt_next   = vlq_count_q + 3'd1;
  assign vlq_done       = !b[7] || (vlq_cnt_next >= 3'(VLQ_MAX_BYTES));
  assign skip_dec       = skip_q - 28'd1;
  assign tempo_acc_next = {tempo_acc_q[15:0], b};
  assign tempo_cnt_next = tempo_cnt_q + 2'd1;
  assign run_two        = has_two_data(run_status_q[7:4]);
  assign run_one        = has_one_data(run_status_q[7:4]);
  assign byte_two       = has_two_data(b[7:4]);
  assign byte_one       = has_one_data(b[7:4]);

  function automatic result_t msg_res(logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
                                      logic [31:0] tk);
    result_t r;
    r             = '0;
    r.kind        = KIND_MSG;
    r.tick        = tk;
    r.msg_type    = st[7:4];
    r.channel     = st[3:0];
    r.first_data  = d1;
    r.second_data = d2;
    return r;
  endfunction

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_EVENT: begin
        if (b == BYTE_META) begin
          phase_d = PH_META_TYPE;
        end else if (b == BYTE_SYSEX || b == BYTE_ESCAPE) begin
          phase_d = PH_SYSEX_LEN;
        end else if (b[7]) begin
          if (byte_two) phase_d = PH_DATA1;
          else if (byte_one) phase_d = PH_DATA_ONE;
          else phase_d = PH_DELTA;
        end else begin
          if (run_two) phase_d = PH_DATA2;
          else if (run_one) phase_d = PH_DELTA;
        end
      end
      PH_DATA1:     phase_d = PH_DATA2;
      PH_DATA2:     phase_d = PH_DELTA;
      PH_DATA_ONE:  phase_d = PH_DELTA;
      PH_META_TYPE: phase_d = PH_META_LEN;
      PH_META_LEN: begin
        if (vlq_done) phase_d = (vlq_next != '0) ? PH_META_BODY : PH_DELTA;
      end
      PH_SYSEX_LEN: begin
        if (vlq_done) phase_d = (vlq_next != '0) ? PH_SYSEX_BODY : PH_DELTA;
      end
      PH_META_BODY, PH_SYSEX_BODY: begin
        if (skip_dec == '0) phase_d = PH_DELTA;
      end
      default: begin
        if (vlq_done || fin) phase_d = PH_EVENT;
      end
    endcase
    if (fin) phase_d = PH_DELTA;
  end

  // datapath and result generation
  always_comb begin
    abs_tick_d   = abs_tick_q;
    vlq_value_d  = vlq_value_q;
    vlq_count_d  = vlq_count_q;
    run_status_d = run_status_q;
    cur_status_d = cur_status_q;
    held_data_d  = held_data_q;
    meta_kind_d  = meta_kind_q;
    skip_d       = skip_q;
    tempo_acc_d  = tempo_acc_q;
    tempo_cnt_d  = tempo_cnt_q;
    max_total_d  = max_total_q;
    tick_add     = '0;
    ev_valid     = 1'b0;
    ev           = '0;
    end_res      = '0;

    unique case (phase_q)
      PH_EVENT: begin
        if (b == BYTE_META) begin
          // meta type follows
        end else if (b == BYTE_SYSEX || b == BYTE_ESCAPE) begin
          vlq_value_d = '0;
          vlq_count_d = '0;
        end else if (b[7]) begin
          cur_status_d = b;
          run_status_d = b;
          if (byte_two || byte_one) begin
            ev_valid = fin;
            ev       = msg_res(b, 8'd0, 8'd0, abs_tick_q);
          end else begin
            vlq_value_d = '0;
            vlq_count_d = '0;
          end
        end else begin
          // data byte under running status
          cur_status_d = run_status_q;
          if (run_two) begin
            ev_valid    = fin;
            ev          = msg_res(run_status_q, 8'd0, 8'd0, abs_tick_q);
            tick_add    = fin ? {24'd0, b} : '0;
            held_data_d = b;
          end else if (run_one) begin
            ev_valid    = 1'b1;
            ev          = msg_res(run_status_q, b, 8'd0, abs_tick_q);
            vlq_value_d = '0;
            vlq_count_d = '0;
          end else begin
            // not a message start: one-byte delta
            tick_add = {24'd0, b};
          end
        end
      end
      PH_DATA1: begin
        ev_valid    = fin;
        ev          = msg_res(cur_status_q, 8'd0, 8'd0, abs_tick_q);
        tick_add    = fin ? {25'd0, b[6:0]} : '0;
        held_data_d = b;
      end
      PH_DATA2: begin
        ev_valid    = 1'b1;
        ev          = msg_res(cur_status_q, held_data_q, b, abs_tick_q);
        vlq_value_d = '0;
        vlq_count_d = '0;
      end
      PH_DATA_ONE: begin
        ev_valid    = 1'b1;
        ev          = msg_res(cur_status_q, b, 8'd0, abs_tick_q);
        vlq_value_d = '0;
        vlq_count_d = '0;
      end
      PH_META_TYPE: begin
        meta_kind_d = b;
        vlq_value_d = '0;
        vlq_count_d = '0;
      end
      PH_META_LEN: begin
        if (vlq_done) begin
          skip_d      = vlq_next;
          vlq_value_d = '0;
          vlq_count_d = '0;
          if (!(meta_kind_q == META_TEMPO && vlq_next == TEMPO_LEN)) meta_kind_d = '0;
          tempo_acc_d = '0;
          tempo_cnt_d = '0;
        end else begin
          vlq_value_d = vlq_next;
          vlq_count_d = vlq_cnt_next;
        end
      end
      PH_META_BODY: begin
        if (meta_kind_q == META_TEMPO) begin
          tempo_acc_d = tempo_acc_next;
          tempo_cnt_d = tempo_cnt_next;
          if (tempo_cnt_next == 2'd3) begin
            ev_valid    = 1'b1;
            ev.kind     = KIND_TEMPO;
            ev.tick     = abs_tick_q;
            ev.tempo_us = tempo_acc_next;
          end
        end
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          vlq_value_d = '0;
          vlq_count_d = '0;
        end
      end
      PH_SYSEX_LEN: begin
        if (vlq_done) begin
          skip_d      = vlq_next;
          vlq_value_d = '0;
          vlq_count_d = '0;
        end else begin
          vlq_value_d = vlq_next;
          vlq_count_d = vlq_cnt_next;
        end
      end
      PH_SYSEX_BODY: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          vlq_value_d = '0;
          vlq_count_d = '0;
        end
      end
      default: begin
        // delta time
        if (vlq_done || fin) begin
          tick_add    = {4'd0, vlq_next};
          vlq_value_d = '0;
          vlq_count_d = '0;
        end else begin
          vlq_value_d = vlq_next;
          vlq_count_d = vlq_cnt_next;
        end
      end
    endcase

    abs_tick_d = tick_sum;

    // end of track: report totals and clear the track state
    if (fin) begin
      if (tick_sum > max_total_q) max_total_d = tick_sum;
      end_res.kind          = KIND_END;
      end_res.tick          = tick_sum;
      end_res.longest_ticks = (tick_sum > max_total_q) ? tick_sum : max_total_q;
      abs_tick_d   = '0;
      vlq_value_d  = '0;
      vlq_count_d  = '0;
      run_status_d = '0;
      cur_status_d = '0;
      held_data_d  = '0;
      meta_kind_d  = '0;
      skip_d       = '0;
      tempo_acc_d  = '0;
      tempo_cnt_d  = '0;
    end
  end

  assign tick_sum = abs_tick_q + tick_add;

  // pack the record for the queue
  always_comb begin
    rec_o     = '0;
    rec_o.two = ev_valid && fin;
    rec_o.r0  = ev_valid ? ev : end_res;
    rec_o.r1  = end_res;
    rec_o.r0.last = !(ev_valid && fin);
    rec_o.r1.last = 1'b1;
  end

  assign push_o = accept && (ev_valid || fin);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DELTA;
      abs_tick_q   <= '0;
      vlq_value_q  <= '0;
      vlq_count_q  <= '0;
      run_status_q <= '0;
      cur_status_q <= '0;
      held_data_q  <= '0;
      meta_kind_q  <= '0;
      skip_q       <= '0;
      tempo_acc_q  <= '0;
      tempo_cnt_q  <= '0;
      max_total_q  <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      abs_tick_q   <= abs_tick_d;
      vlq_value_q  <= vlq_value_d;
      vlq_count_q  <= vlq_count_d;
      run_status_q <= run_status_d;
      cur_status_q <= cur_status_d;
      held_data_q  <= held_data_d;
      meta_kind_q  <= meta_kind_d;
      skip_q       <= skip_d;
      tempo_acc_q  <= tempo_acc_d;
      tempo_cnt_q  <= tempo_cnt_d;
      max_total_q  <= max_total_d;
    end
  end

endmodule

@@ design/mtep_queue.sv @@
// short record queue between parser front end and output stage
// depends on mtep_pkg and the assertion macro header
`include "midi_track_event_parser_top_assert.svh"
module mtep_queue import mtep_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  rec_t   rec_i,
  input  logic   pop_i,
  output rec_t   head_o,
  output qstat_t stat_o
);

  rec_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              full;
  logic              empty;

  assign full         = (cnt_q == QCNT_W'(QDEPTH));
  assign empty        = (cnt_q == '0);
  assign stat_o.full  = full;
  assign stat_o.empty = empty;
  assign head_o       = mem_q[rd_ptr_q];

  // record storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  `MTEP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= QCNT_W'(QDEPTH))
  `MTEP_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full)
  `MTEP_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty)
  `MTEP_ASSERT(a_push_fills, clk_i, rst_ni, (push_i && !pop_i) |=> !empty)

endmodule

@@ design/mtep_back.sv @@
// output stage: splits each queued record into one or two result beats
// depends on mtep_pkg and mtep_out_if
module mtep_back import mtep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rec_t      head_i,
  input  qstat_t    q_stat_i,
  output logic      pop_o,
  mtep_out_if.source out_o
);

  logic    out_valid_q, out_valid_d;
  logic    sel_q, sel_d;
  result_t out_q;
  logic    load;

  // load the output register whenever the queue holds a record and the register is free or being taken
  assign load  = !q_stat_i.empty && (!out_valid_q || out_o.ready);
  assign pop_o = load && (sel_q || !head_i.two);

  always_comb begin
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    if (load) begin
      out_valid_d = 1'b1;
      sel_d       = head_i.two && !sel_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) out_q <= sel_q ? head_i.r1 : head_i.r0;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.tick          = out_q.tick;
  assign out_o.msg_type      = out_q.msg_type;
  assign out_o.channel       = out_q.channel;
  assign out_o.first_data    = out_q.first_data;
  assign out_o.second_data   = out_q.second_data;
  assign out_o.tempo_us      = out_q.tempo_us;
  assign out_o.longest_ticks = out_q.longest_ticks;
  assign out_o.last          = out_q.last;

endmodule
